// ----- sv/netlist_token_splitter_top_macros.svh -----
// assertion macros for the netlist token splitter
`ifndef NETLIST_TOKEN_SPLITTER_TOP_MACROS_SVH
`define NETLIST_TOKEN_SPLITTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define NTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same cycle implication");

`define NTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next cycle implication");

`else

`define NTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define NTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/nts_pkg.sv -----
// types, constants and character classes shared by the token splitter
`default_nettype none

package nts_pkg;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_LINE = 2'd2;

	localparam logic [3:0] TYPE_NONE     = 4'd0;
	localparam logic [3:0] TYPE_STRING   = 4'd1;
	localparam logic [3:0] TYPE_NULL     = 4'd2;
	localparam logic [3:0] TYPE_LBRACKET = 4'd3;
	localparam logic [3:0] TYPE_RBRACKET = 4'd4;
	localparam logic [3:0] TYPE_LT       = 4'd5;
	localparam logic [3:0] TYPE_GT       = 4'd6;
	localparam logic [3:0] TYPE_PERCENT  = 4'd7;
	localparam logic [3:0] TYPE_TILDE    = 4'd8;

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_PLAIN  = 2'd1;
	localparam logic [1:0] MODE_QUOTED = 2'd2;

	localparam logic [2:0] NP_START = 3'd0;
	localparam logic [2:0] NP_MATCH = 3'd4;
	localparam logic [2:0] NP_FAIL  = 3'd7;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_VT     = 8'h0b;
	localparam logic [7:0] CH_FF     = 8'h0c;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_LBRK   = 8'h5b;
	localparam logic [7:0] CH_RBRK   = 8'h5d;
	localparam logic [7:0] CH_L      = 8'h6c;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_TILDE  = 8'h7e;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] chr;
		logic [3:0] ttype;
	} res_t;

	typedef struct packed {
		logic [1:0]       n;
		res_t [2:0]       res;
	} desc_t;

	function automatic logic is_skip(input logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR,
			CH_EQ, CH_LPAREN, CH_RPAREN, CH_COMMA};
	endfunction

	function automatic logic [3:0] single_type(input logic [7:0] c);
		logic [3:0] t;
		case (c)
			CH_LBRK:  t = TYPE_LBRACKET;
			CH_RBRK:  t = TYPE_RBRACKET;
			CH_LT:    t = TYPE_LT;
			CH_GT:    t = TYPE_GT;
			CH_PCT:   t = TYPE_PERCENT;
			CH_TILDE: t = TYPE_TILDE;
			default:  t = TYPE_NONE;
		endcase
		return t;
	endfunction

	function automatic logic [7:0] null_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = CH_N;
			3'd1:    c = CH_U;
			3'd2:    c = CH_L;
			3'd3:    c = CH_L;
			default: c = CH_N;
		endcase
		return c;
	endfunction

	function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] chr,
		input logic [3:0] ttype);
		res_t r;
		r.kind  = kind;
		r.chr   = chr;
		r.ttype = ttype;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/netlist_token_splitter_top.sv -----
// top level of the netlist token splitter
//
// input channel: one line character per transfer on ch (in_valid/in_ready);
// a zero byte ends the line. output channel (out_valid/out_ready) carries
// results: kind 0 a token character in chr, kind 1 a token end with its
// type in token_type, kind 2 the line end. last marks the final result
// caused by one input character. skip characters outside a token and an
// opening quote cause no result.
// a character's descriptor passes through the queue and then the output
// register before its first result is offered.
// throughput: one character per cycle while each causes at most one result
// and the receiver does not stall; the output port gives one result per cycle
// while out_ready is high, so a character causing two or three results holds the output until all are taken.
// the descriptor queue (QUEUE_DEPTH entries) lets the input keep taking
// characters while the receiver stalls, and in_ready drops once it is full.
// reset: asynchronous, clears the token state, the queue and the output.
`default_nettype none

module netlist_token_splitter_top import nts_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      chr,
	output logic [3:0]      token_type,
	output logic            last
);

	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_empty;
	desc_t q_wdata;
	desc_t q_rdata;

	nts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ch       (ch),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	nts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	nts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.chr        (chr),
		.token_type (token_type),
		.last       (last)
	);

endmodule

`default_nettype wire

// ----- sv/nts_front.sv -----
// front end: takes characters, tracks token state, builds result descriptors
`default_nettype none
`include "netlist_token_splitter_top_macros.svh"

module nts_front import nts_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	input  wire logic       q_full,
	output logic            q_push,
	output desc_t           q_data
);

	logic [1:0] mode_q;
	logic [7:0] first_q;
	logic [2:0] np_q;
	logic       empty_q;

	logic [1:0] mode_d;
	logic [7:0] first_d;
	logic [2:0] np_d;
	logic       empty_d;

	logic       active;
	logic       skip;
	logic [3:0] st;
	logic [3:0] first_st;
	logic [3:0] end_ty;
	logic [2:0] app_np;
	logic [7:0] app_first;
	logic       xfer;
	desc_t      desc;

	always_comb begin
		active    = (mode_q == MODE_PLAIN) || (mode_q == MODE_QUOTED);
		skip      = is_skip(ch);
		st        = single_type(ch);
		first_st  = single_type(first_q);
		if (empty_q) begin
			end_ty = TYPE_STRING;
		end else if (first_st != TYPE_NONE) begin
			end_ty = first_st;
		end else if (np_q == NP_MATCH) begin
			end_ty = TYPE_NULL;
		end else begin
			end_ty = TYPE_STRING;
		end
		app_np    = (np_q < NP_MATCH && ch == null_char(np_q)) ? np_q + 3'd1 : NP_FAIL;
		app_first = empty_q ? ch : first_q;

		desc    = '0;
		mode_d  = mode_q;
		first_d = first_q;
		np_d    = np_q;
		empty_d = empty_q;

		if (active) begin
			if (ch == CH_NUL) begin
				desc.n      = 2'd2;
				desc.res[0] = mk_res(KIND_END, CH_NUL, end_ty);
				desc.res[1] = mk_res(KIND_LINE, CH_NUL, TYPE_NONE);
				mode_d = MODE_IDLE; first_d = CH_NUL; np_d = NP_START; empty_d = 1'b1;
			end else if (mode_q == MODE_QUOTED) begin
				desc.n = 2'd1;
				if (ch == CH_QUOTE) begin
					desc.res[0] = mk_res(KIND_END, CH_NUL, end_ty);
					mode_d = MODE_IDLE; first_d = CH_NUL; np_d = NP_START; empty_d = 1'b1;
				end else begin
					desc.res[0] = mk_res(KIND_CHAR, ch, TYPE_NONE);
					first_d = app_first; np_d = app_np; empty_d = 1'b0;
				end
			end else if (skip) begin
				desc.n      = 2'd1;
				desc.res[0] = mk_res(KIND_END, CH_NUL, end_ty);
				mode_d = MODE_IDLE; first_d = CH_NUL; np_d = NP_START; empty_d = 1'b1;
			end else if (st != TYPE_NONE) begin
				desc.n      = 2'd3;
				desc.res[0] = mk_res(KIND_END, CH_NUL, end_ty);
				desc.res[1] = mk_res(KIND_CHAR, ch, TYPE_NONE);
				desc.res[2] = mk_res(KIND_END, CH_NUL, st);
				mode_d = MODE_IDLE; first_d = CH_NUL; np_d = NP_START; empty_d = 1'b1;
			end else begin
				desc.n      = 2'd1;
				desc.res[0] = mk_res(KIND_CHAR, ch, TYPE_NONE);
				first_d = app_first; np_d = app_np; empty_d = 1'b0;
			end
		end else begin
			if (ch == CH_NUL) begin
				desc.n      = 2'd1;
				desc.res[0] = mk_res(KIND_LINE, CH_NUL, TYPE_NONE);
				mode_d = MODE_IDLE; first_d = CH_NUL; np_d = NP_START; empty_d = 1'b1;
			end else if (skip) begin
				mode_d = MODE_IDLE;
			end else if (st != TYPE_NONE) begin
				desc.n      = 2'd2;
				desc.res[0] = mk_res(KIND_CHAR, ch, TYPE_NONE);
				desc.res[1] = mk_res(KIND_END, CH_NUL, st);
				mode_d = MODE_IDLE; first_d = CH_NUL; np_d = NP_START; empty_d = 1'b1;
			end else if (ch == CH_QUOTE) begin
				mode_d = MODE_QUOTED; first_d = CH_NUL; np_d = NP_START; empty_d = 1'b1;
			end else begin
				desc.n      = 2'd1;
				desc.res[0] = mk_res(KIND_CHAR, ch, TYPE_NONE);
				mode_d  = MODE_PLAIN;
				first_d = ch;
				np_d    = (ch == null_char(NP_START)) ? 3'd1 : NP_FAIL;
				empty_d = 1'b0;
			end
		end
	end

	assign in_ready = !q_full;
	assign xfer     = in_valid && in_ready;
	assign q_push   = xfer && (desc.n != 2'd0);
	assign q_data   = desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			first_q <= CH_NUL;
			np_q    <= NP_START;
			empty_q <= 1'b1;
		end else if (xfer) begin
			mode_q  <= mode_d;
			first_q <= first_d;
			np_q    <= np_d;
			empty_q <= empty_d;
		end
	end

	`NTS_ASSERT_NEXT(a_line_end_resets, clk, arst_n, xfer && ch == CH_NUL, mode_q == MODE_IDLE && empty_q && np_q == NP_START)

endmodule

`default_nettype wire

// ----- sv/nts_queue.sv -----
// short descriptor queue between front and back
`default_nettype none
`include "netlist_token_splitter_top_macros.svh"

module nts_queue import nts_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_data,
	output logic       full,
	input  wire logic  pop,
	output desc_t      pop_data,
	output logic       empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`NTS_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full || pop)
	`NTS_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !empty)

endmodule

`default_nettype wire

// ----- sv/nts_back.sv -----
// back end: plays out the results of each descriptor, one transfer per cycle while out_ready is high
`default_nettype none
`include "netlist_token_splitter_top_macros.svh"

module nts_back import nts_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_empty,
	input  wire desc_t      q_data,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      chr,
	output logic [3:0]      token_type,
	output logic            last
);

	desc_t      hold_q;
	logic       hold_valid_q;
	logic [1:0] idx_q;
	res_t       cur;
	logic       take;
	logic       done;

	always_comb begin
		case (idx_q)
			2'd1:    cur = hold_q.res[1];
			2'd2:    cur = hold_q.res[2];
			default: cur = hold_q.res[0];
		endcase
	end

	assign out_valid  = hold_valid_q;
	assign kind       = cur.kind;
	assign chr        = cur.chr;
	assign token_type = cur.ttype;
	assign last       = (idx_q == hold_q.n - 2'd1);

	assign take  = hold_valid_q && out_ready;
	assign done  = take && last;
	assign q_pop = (!hold_valid_q || done) && !q_empty;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			hold_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			idx_q        <= 2'd0;
		end else if (q_pop) begin
			hold_valid_q <= 1'b1;
			idx_q        <= 2'd0;
		end else if (done) begin
			hold_valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	`NTS_ASSERT_IMP(a_desc_not_empty, clk, arst_n, hold_valid_q, hold_q.n != 2'd0 && idx_q < hold_q.n)
	`NTS_ASSERT_IMP(a_line_end_is_last, clk, arst_n, hold_valid_q && cur.kind == KIND_LINE, last)

endmodule

`default_nettype wire

// ----- tb/netlist_token_splitter_top_test.sv -----
// self-checking testbench for netlist_token_splitter_top with a built-in token predictor
`default_nettype none

module netlist_token_splitter_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import nts_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] chr;
		logic [3:0] ttype;
		logic       last;
	} tok_res_t;

	localparam int RANDOM_CHARS = 125;
	localparam int STALL_AT     = 40;
	localparam int STALL_CYCLES = 60;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] ch = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] chr;
	logic [3:0] token_type;
	logic       last;

	netlist_token_splitter_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ch         (ch),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.chr        (chr),
		.token_type (token_type),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [1:0] tok_mode;
	logic [7:0] tok_first;
	logic [2:0] null_seen;
	logic       tok_none;
	tok_res_t   tok_expect_q[$];

	logic [7:0] line_q[$];
	logic [7:0] null_word[4] = '{CH_N, CH_U, CH_L, CH_L};
	logic [7:0] skip_set[10] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR,
		CH_EQ, CH_LPAREN, CH_RPAREN, CH_COMMA};
	logic [7:0] lone_set[6] = '{CH_LBRK, CH_RBRK, CH_LT, CH_GT, CH_PCT, CH_TILDE};

	int n_chars = 0;
	int n_lines = 0;
	int n_results = 0;
	int n_ends = 0;
	int n_nulls = 0;
	int n_errors = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b1;
	bit rx_hold = 1'b0;

	function automatic bit delim_char(input logic [7:0] c);
		case (c)
			CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR,
			CH_EQ, CH_LPAREN, CH_RPAREN, CH_COMMA: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [3:0] lone_type(input logic [7:0] c);
		case (c)
			CH_LBRK:  return TYPE_LBRACKET;
			CH_RBRK:  return TYPE_RBRACKET;
			CH_LT:    return TYPE_LT;
			CH_GT:    return TYPE_GT;
			CH_PCT:   return TYPE_PERCENT;
			CH_TILDE: return TYPE_TILDE;
			default:  return TYPE_NONE;
		endcase
	endfunction

	function void clear_token();
		tok_first = CH_NUL;
		null_seen = NP_START;
		tok_none = 1'b1;
	endfunction

	function void emit(input logic [1:0] k, input logic [7:0] c, input logic [3:0] t);
		tok_res_t r;
		r.kind = k;
		r.chr = c;
		r.ttype = t;
		r.last = 1'b0;
		tok_expect_q.push_back(r);
	endfunction

	function void add_char(input logic [7:0] c);
		if (tok_none)
			tok_first = c;
		tok_none = 1'b0;
		if (null_seen < NP_MATCH && c == null_word[null_seen[1:0]])
			null_seen = null_seen + 3'd1;
		else
			null_seen = NP_FAIL;
		emit(KIND_CHAR, c, TYPE_NONE);
	endfunction

	function void close_token();
		logic [3:0] t;
		t = tok_none ? TYPE_NONE : lone_type(tok_first);
		if (t == TYPE_NONE)
			t = (!tok_none && null_seen == NP_MATCH) ? TYPE_NULL : TYPE_STRING;
		tok_mode = MODE_IDLE;
		clear_token();
		emit(KIND_END, CH_NUL, t);
	endfunction

	function void predict_char(input logic [7:0] c);
		int       start;
		bit       done;
		tok_res_t r;
		start = tok_expect_q.size();
		done = 1'b0;
		if (tok_mode == MODE_PLAIN || tok_mode == MODE_QUOTED) begin
			if (c == CH_NUL) begin
				close_token();
			end else if (tok_mode == MODE_QUOTED) begin
				if (c == CH_QUOTE)
					close_token();
				else
					add_char(c);
				done = 1'b1;
			end else if (delim_char(c)) begin
				close_token();
				done = 1'b1;
			end else if (lone_type(c) != TYPE_NONE) begin
				close_token();
			end else begin
				add_char(c);
				done = 1'b1;
			end
		end
		if (!done) begin
			if (c == CH_NUL) begin
				tok_mode = MODE_IDLE;
				clear_token();
				emit(KIND_LINE, CH_NUL, TYPE_NONE);
			end else if (delim_char(c)) begin
				tok_mode = MODE_IDLE;
			end else if (lone_type(c) != TYPE_NONE) begin
				clear_token();
				add_char(c);
				close_token();
			end else if (c == CH_QUOTE) begin
				clear_token();
				tok_mode = MODE_QUOTED;
			end else begin
				clear_token();
				tok_mode = MODE_PLAIN;
				add_char(c);
			end
		end
		if (tok_expect_q.size() > start) begin
			r = tok_expect_q.pop_back();
			r.last = 1'b1;
			tok_expect_q.push_back(r);
		end
	endfunction

	task push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 3))
			0, 1:    return null_word[$urandom_range(0, 2)];
			2:       return 8'($urandom_range(8'h61, 8'h7a));
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task gen_line();
		int   pieces;
		int   len;
		logic [7:0] c;
		pieces = $urandom_range(1, 6);
		for (int p = 0; p < pieces; p++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					len = $urandom_range(1, 6);
					for (int i = 0; i < len; i++)
						line_q.push_back(word_char());
				end
				3: for (int i = 0; i < 4; i++) line_q.push_back(null_word[i]);
				4: begin
					// prefixes and extensions of the null word, or the word itself
					len = $urandom_range(1, 5);
					for (int i = 0; i < len; i++)
						line_q.push_back(i < 4 ? null_word[i] : CH_L);
					if ($urandom_range(0, 1))
						line_q.push_back(word_char());
				end
				5, 9: begin
					line_q.push_back(CH_QUOTE);
					len = $urandom_range(0, 4);
					for (int i = 0; i < len; i++) begin
						if (p[0])
							c = (i < 4) ? null_word[i] : CH_N;
						else
							c = 8'($urandom_range(1, 255));
						if (c == CH_QUOTE)
							c = skip_set[$urandom_range(0, 9)];
						line_q.push_back(c);
					end
					if ($urandom_range(0, 9) != 0)
						line_q.push_back(CH_QUOTE);
				end
				6: line_q.push_back(lone_set[$urandom_range(0, 5)]);
				7: begin
					len = $urandom_range(1, 3);
					for (int i = 0; i < len; i++)
						line_q.push_back(skip_set[$urandom_range(0, 9)]);
				end
				default: line_q.push_back(8'($urandom_range(1, 255)));
			endcase
			if ($urandom_range(0, 9) < 7)
				line_q.push_back(skip_set[$urandom_range(0, 9)]);
		end
		line_q.push_back(CH_NUL);
	endtask

	function void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endfunction

	// input side: one transfer per character, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			ch <= CH_NUL;
			tx_wait = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_char(ch);
				n_chars++;
				if (ch == CH_NUL)
					n_lines++;
			end
			if (!in_valid || in_ready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (line_q.size() != 0) begin
					in_valid <= 1'b1;
					ch <= line_q.pop_front();
					if ($urandom_range(0, 15) == 0)
						tx_calm = !tx_calm;
					tx_wait = (tx_calm || rx_hold) ? 0 : $urandom_range(0, 8);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: compare each transfer with the oldest expected result
	always @(posedge clk or negedge arst_n) begin
		tok_res_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_hold <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (tok_expect_q.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected result, expected none, actual kind %0d chr %0d type %0d last %0d",
						$time, kind, chr, token_type, last);
				end else begin
					e = tok_expect_q.pop_front();
					check_field("kind", e.kind, kind);
					check_field("chr", e.chr, chr);
					check_field("token_type", e.ttype, token_type);
					check_field("last", e.last, last);
					if (e.kind == KIND_END) begin
						n_ends++;
						if (e.ttype == TYPE_NULL)
							n_nulls++;
					end
				end
				if ($urandom_range(0, 15) == 0)
					rx_calm = !rx_calm;
				rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
				if (n_results == STALL_AT)
					rx_wait = STALL_CYCLES;
			end
			rx_hold <= (rx_wait > 8);
			if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		tok_mode = MODE_IDLE;
		clear_token();

		// plain token cut by a less-than sign, skip, empty quotes, null word
		push_text("ab<=\"\"null ");
		// quoted text with a leading skip, cut by end of line
		push_text("\" x");
		line_q.push_back(CH_NUL);
		// quote inside a plain token, high characters, the one-char tokens other than <
		push_text("a\"");
		line_q.push_back(8'hff);
		line_q.push_back(8'h80);
		push_text("[]~%>");
		line_q.push_back(CH_NUL);

		while (line_q.size() < RANDOM_CHARS + 25)
			gen_line();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (line_q.size() != 0 || in_valid)
			@(posedge clk);
		while (tok_expect_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (tok_expect_q.size() != 0) begin
			n_errors++;
			$display("%0t: %0d expected results never arrived", $time, tok_expect_q.size());
		end
		$display("covered %0d characters over %0d lines, %0d results checked", n_chars,
			n_lines, n_results);
		$display("token ends seen: %0d, of them %0d typed null", n_ends, n_nulls);
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout");
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
